### src/fpa_pkg.sv
// ----------------------------------------------------------------------------
// fpa_pkg: shared types and codes for the fixed partition allocator
// Item structs, operation and policy codes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package fpa_pkg;

    localparam int MAX_BLOCKS_DEF = 16;
    localparam int SIZE_BITS_DEF  = 16;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_ALLOC = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [1:0] POL_FIRST = 2'd0;
    localparam logic [1:0] POL_BEST  = 2'd1;
    localparam logic [1:0] POL_WORST = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_FIT_POLICY  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 2'd1;

    localparam logic [4:0] BLOCK_COUNT_RST = 5'd16;

    typedef struct packed {
        logic [1:0]  op;
        logic [3:0]  block_index;
        logic [15:0] amount;
        logic [7:0]  request_id;
    } t_fpa_in;

    typedef struct packed {
        logic [7:0]  result_id;
        logic        granted;
        logic [3:0]  chosen_block;
        logic [15:0] chosen_size;
    } t_fpa_out;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } t_fpa_state;

    typedef struct packed {
        logic load;
        logic clear;
        logic start;
        logic issue;
        logic load_out;
    } t_fpa_cmd;

    typedef struct packed {
        logic empty;
        logic scan_last;
        logic out_free;
    } t_fpa_sts;

endpackage

`default_nettype wire

### src/fixed_partition_allocator_core.sv
// ----------------------------------------------------------------------------
// fixed_partition_allocator_core: fixed partition allocator
// Partition table with first, best and worst fit allocation.
// ----------------------------------------------------------------------------
// Load and free-all items are handled in the idle state and do not leave it.
// An allocate item passes from acceptance through the scan (skipped when the
// partition count is zero), a drain step and the done state to the result
// register: the scan reads one partition size from the size memory per
// cycle through its single read port and compares it against the request
// and the running pick. The next item is taken as soon as the result sits in
// the output register, even if it is still stalled there; an allocate
// that finishes while an earlier result is still stalled waits for it to leave.
`default_nettype none

module fixed_partition_allocator_core #(
    parameter int MAX_BLOCKS = fpa_pkg::MAX_BLOCKS_DEF,
    parameter int SIZE_BITS  = fpa_pkg::SIZE_BITS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire fpa_pkg::t_fpa_in                 i_in_data,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output fpa_pkg::t_fpa_out                     o_out_data,
    input  wire logic                             i_cfg_we,
    input  wire logic [fpa_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [fpa_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import fpa_pkg::*;

    t_fpa_cmd cmd;
    t_fpa_sts sts;

    fpa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (i_in_data.op),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    fpa_dp #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .SIZE_BITS  (SIZE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

### src/fpa_ctrl.sv
// ----------------------------------------------------------------------------
// fpa_ctrl: allocator controller
// Takes items in idle, runs the partition scan and hands the answer to the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module fpa_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic [1:0]        i_op,
    input  wire fpa_pkg::t_fpa_sts i_sts,
    output fpa_pkg::t_fpa_cmd      o_cmd,
    output logic                   o_in_stall
);
    import fpa_pkg::*;

    t_fpa_state r_state;
    t_fpa_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    unique case (i_op)
                        OP_LOAD:  o_cmd.load  = 1'b1;
                        OP_CLEAR: o_cmd.clear = 1'b1;
                        OP_ALLOC: begin
                            o_cmd.start = 1'b1;
                            n_state     = i_sts.empty ? ST_DONE : ST_SCAN;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCAN: begin
                o_cmd.issue = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

### src/fpa_dp.sv
// ----------------------------------------------------------------------------
// fpa_dp: allocator datapath
// Size memory, used marks, configuration registers, one-compare-per-cycle
// scan with running pick, and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module fpa_dp #(
    parameter int MAX_BLOCKS = fpa_pkg::MAX_BLOCKS_DEF,
    parameter int SIZE_BITS  = fpa_pkg::SIZE_BITS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire fpa_pkg::t_fpa_in                 i_in_data,
    input  wire fpa_pkg::t_fpa_cmd                i_cmd,
    output fpa_pkg::t_fpa_sts                     o_sts,
    input  wire logic                             i_cfg_we,
    input  wire logic [fpa_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [fpa_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output fpa_pkg::t_fpa_out                     o_out_data
);
    import fpa_pkg::*;

    localparam int AW   = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CW   = $clog2(MAX_BLOCKS + 1);
    localparam int CMPW = (SIZE_BITS > 16) ? SIZE_BITS : 16;

    logic [SIZE_BITS-1:0]  r_mem [MAX_BLOCKS];
    logic [MAX_BLOCKS-1:0] r_used;
    logic [1:0]            r_fit_policy;
    logic [4:0]            r_block_count;

    logic [AW-1:0]         r_scan_idx;
    logic                  r_rd_vld;
    logic [SIZE_BITS-1:0]  r_rd_data;
    logic                  r_rd_used;
    logic [AW-1:0]         r_rd_idx;

    logic [15:0]           r_amount;
    logic [7:0]            r_rid;
    logic                  r_found;
    logic [AW-1:0]         r_pick;
    logic [SIZE_BITS-1:0]  r_best;

    logic                  r_out_valid;
    t_fpa_out              r_out;

    logic [CW-1:0]         count;
    logic                  load_ok;
    logic [AW-1:0]         load_addr;
    logic [CMPW-1:0]       rd_ext;
    logic [CMPW-1:0]       best_ext;
    logic [CMPW-1:0]       amt_ext;
    logic                  fits;
    logic                  take;

    assign count = ({27'd0, r_block_count} > 32'(MAX_BLOCKS)) ? CW'(MAX_BLOCKS)
                                                             : CW'(r_block_count);
    assign load_ok   = ({28'd0, i_in_data.block_index} < 32'(MAX_BLOCKS));
    assign load_addr = AW'(i_in_data.block_index);

    assign o_sts.empty     = (count == '0);
    assign o_sts.scan_last = ((CW'(r_scan_idx) + CW'(1)) == count);
    assign o_sts.out_free  = !r_out_valid || !i_out_stall;

    assign rd_ext   = CMPW'(r_rd_data);
    assign best_ext = CMPW'(r_best);
    assign amt_ext  = CMPW'(r_amount);
    assign fits     = r_rd_vld && !r_rd_used && (rd_ext >= amt_ext);
    assign take     = fits && (!r_found ||
                               ((r_fit_policy == POL_BEST)  && (rd_ext < best_ext)) ||
                               ((r_fit_policy == POL_WORST) && (rd_ext > best_ext)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit_policy  <= POL_FIRST;
            r_block_count <= BLOCK_COUNT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FIT_POLICY:  r_fit_policy  <= i_cfg_data[1:0];
                CFG_BLOCK_COUNT: r_block_count <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && load_ok) begin
            r_mem[load_addr] <= SIZE_BITS'(i_in_data.amount);
        end
        if (i_cmd.issue) begin
            r_rd_data <= r_mem[r_scan_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (i_cmd.clear) begin
            r_used <= '0;
        end else if (i_cmd.load && load_ok) begin
            r_used[load_addr] <= 1'b0;
        end else if (i_cmd.load_out && r_found) begin
            r_used[r_pick] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
            r_found  <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.issue;
            if (i_cmd.start) begin
                r_found <= 1'b0;
            end else if (take) begin
                r_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_scan_idx <= '0;
            r_amount   <= i_in_data.amount;
            r_rid      <= i_in_data.request_id;
        end else if (i_cmd.issue) begin
            r_scan_idx <= r_scan_idx + AW'(1);
        end
        if (i_cmd.issue) begin
            r_rd_used <= r_used[r_scan_idx];
            r_rd_idx  <= r_scan_idx;
        end
        if (take) begin
            r_pick <= r_rd_idx;
            r_best <= r_rd_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out.result_id    <= r_rid;
            r_out.granted      <= r_found;
            r_out.chosen_block <= r_found ? 4'(r_pick) : 4'd0;
            r_out.chosen_size  <= r_found ? 16'(r_best) : 16'd0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_pick_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load_out && r_found) |-> !r_used[r_pick])
        else $error("chosen partition already marked used");

    a_pick_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_found |-> (best_ext >= amt_ext))
        else $error("chosen partition smaller than request");

    a_mark_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load_out && r_found) |=> r_used[$past(r_pick)])
        else $error("granted partition not marked used");

endmodule

`default_nettype wire

### sim/fixed_partition_allocator_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_partition_allocator_core_tb: partition allocator regression
// Loads every partition, runs directed allocations, then random traffic
// under every fit policy and several partition counts. A local predictor
// tracks partition sizes and used marks and checks each grant in order.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_partition_allocator_core_tb;

    import fpa_pkg::*;

    localparam int MAX_BLOCKS = MAX_BLOCKS_DEF;
    localparam logic [1:0] OP_RESERVED = 2'd3;
    localparam logic [1:0] POL_UNDEFINED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_B = 2'd3;
    localparam int PHASES = 9;
    localparam int PHASE_ITEMS = 107;
    localparam int SETTLE_CYCLES = 40;

    localparam logic [15:0] SEED_SIZES [16] = '{
        16'd0, 16'hFFFF, 16'd500, 16'd500, 16'd1000, 16'hFFFF, 16'd1, 16'd2000,
        16'd300, 16'd40000, 16'd500, 16'd12345, 16'h8000, 16'h7FFF, 16'd250, 16'd1000
    };
    localparam logic [4:0] PHASE_COUNTS [PHASES] = '{
        5'd16, 5'd1, 5'd31, 5'd0, 5'd8, 5'd16, 5'd2, 5'd12, 5'd17
    };

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 o_in_stall;
    t_fpa_in              in_data = '0;
    logic                 o_out_valid;
    logic                 out_stall = 1'b0;
    t_fpa_out             o_out_data;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    t_fpa_in  pending_items[$];
    t_fpa_out expected_grants[$];
    int       fail_count = 0;
    int       send_idle_pct = 0;
    int       recv_stall_pct = 0;

    logic [15:0] part_size [MAX_BLOCKS];
    logic        part_used [MAX_BLOCKS] = '{default: 1'b0};
    logic [1:0]  fit_policy = POL_FIRST;
    logic [4:0]  active_count = BLOCK_COUNT_RST;
    logic [15:0] gen_sizes [MAX_BLOCKS] = '{default: 16'd0};

    fixed_partition_allocator_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic void apply_partition_op(t_fpa_in it);
        t_fpa_out res;
        int       span;
        int       pick;
        bit       hit;
        res = '0;
        pick = 0;
        hit = 1'b0;
        case (it.op)
            OP_LOAD: begin
                part_size[it.block_index] = it.amount;
                part_used[it.block_index] = 1'b0;
            end
            OP_CLEAR: begin
                foreach (part_used[k]) part_used[k] = 1'b0;
            end
            OP_ALLOC: begin
                span = (active_count > MAX_BLOCKS) ? MAX_BLOCKS : int'(active_count);
                for (int j = 0; j < span; j++) begin
                    if (!part_used[j] && part_size[j] >= it.amount) begin
                        if (!hit) begin
                            hit = 1'b1;
                            pick = j;
                            if (fit_policy != POL_BEST && fit_policy != POL_WORST) break;
                        end else if (fit_policy == POL_BEST &&
                                     part_size[j] < part_size[pick]) begin
                            pick = j;
                        end else if (fit_policy == POL_WORST &&
                                     part_size[j] > part_size[pick]) begin
                            pick = j;
                        end
                    end
                end
                res.result_id = it.request_id;
                if (hit) begin
                    part_used[pick] = 1'b1;
                    res.granted = 1'b1;
                    res.chosen_block = 4'(pick);
                    res.chosen_size = part_size[pick];
                end
                expected_grants.push_back(res);
            end
            default: ;
        endcase
    endfunction

    function automatic void queue_item(logic [1:0] op, logic [3:0] idx, logic [15:0] amt,
                                       logic [7:0] id);
        t_fpa_in it;
        it.op = op;
        it.block_index = idx;
        it.amount = amt;
        it.request_id = id;
        if (op == OP_LOAD) gen_sizes[idx] = amt;
        pending_items.push_back(it);
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        if (idx == CFG_FIT_POLICY) fit_policy = data[1:0];
        else if (idx == CFG_BLOCK_COUNT) active_count = data;
    endtask

    task automatic wait_until_quiet();
        do @(negedge i_clk);
        while (pending_items.size() != 0 || in_valid || expected_grants.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin : driver
        logic hold;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !o_in_stall) apply_partition_op(in_data);
            hold = in_valid && o_in_stall;
            if (!hold && pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                in_data <= pending_items.pop_front();
                in_valid <= 1'b1;
            end else if (!hold) begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : monitor
        t_fpa_out want;
        if (i_rst_n && o_out_valid && !out_stall) begin
            if (expected_grants.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("%0t unexpected result id=%h granted=%b block=%0d size=%h",
                             $realtime, o_out_data.result_id, o_out_data.granted,
                             o_out_data.chosen_block, o_out_data.chosen_size);
            end else begin
                want = expected_grants.pop_front();
                if (o_out_data.result_id !== want.result_id ||
                    o_out_data.granted !== want.granted ||
                    o_out_data.chosen_block !== want.chosen_block ||
                    o_out_data.chosen_size !== want.chosen_size) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display({"%0t grant mismatch: exp id=%h g=%b blk=%0d size=%h, ",
                                  "got id=%h g=%b blk=%0d size=%h"},
                                 $realtime, want.result_id, want.granted, want.chosen_block,
                                 want.chosen_size, o_out_data.result_id, o_out_data.granted,
                                 o_out_data.chosen_block, o_out_data.chosen_size);
                end
            end
        end
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    initial begin
        int          taken;
        int          sel;
        logic [1:0]  op;
        logic [15:0] amt;
        logic [15:0] ref_size;
        logic [3:0]  idx;
        send_idle_pct = 25;
        recv_stall_pct = 64;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // write every partition before any scan can reach it
        for (int k = 0; k < MAX_BLOCKS; k++) queue_item(OP_LOAD, 4'(k), SEED_SIZES[k], 8'h00);
        queue_item(OP_ALLOC, 4'hF, 16'd0, 8'h00);
        queue_item(OP_ALLOC, 4'h0, 16'hFFFF, 8'hFF);
        queue_item(OP_ALLOC, 4'h0, 16'hFFFF, 8'h5A);
        queue_item(OP_ALLOC, 4'h0, 16'hFFFF, 8'hA5);
        queue_item(OP_RESERVED, 4'hF, 16'hFFFF, 8'hFF);
        queue_item(OP_CLEAR, 4'h0, 16'h0000, 8'h00);
        queue_item(OP_ALLOC, 4'h0, 16'hFFFF, 8'h11);
        queue_item(OP_LOAD, 4'hF, 16'hFFFF, 8'h22);
        queue_item(OP_ALLOC, 4'h0, 16'd1, 8'h33);
        wait_until_quiet();

        for (int p = 0; p < PHASES; p++) begin
            if (p < 3) begin
                send_idle_pct = 25;
                recv_stall_pct = 64;
            end else if (p < 6) begin
                send_idle_pct = 64;
                recv_stall_pct = 25;
            end else begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            write_reg(CFG_FIT_POLICY, {3'($urandom_range(7)), 2'(p % 4)});
            write_reg(CFG_BLOCK_COUNT,
                      (p == 7) ? 5'($urandom_range(1, 16)) : PHASE_COUNTS[p]);
            write_reg((p % 2) ? CFG_UNMAPPED_B : CFG_UNMAPPED_A, 5'($urandom_range(31)));
            @(negedge i_clk);

            taken = 0;
            while (taken < PHASE_ITEMS) begin
                sel = $urandom_range(99);
                idx = 4'($urandom_range(15));
                ref_size = gen_sizes[$urandom_range(MAX_BLOCKS - 1)];
                if (sel < 50) begin
                    op = OP_ALLOC;
                    case ($urandom_range(3))
                        0: amt = 16'($urandom_range(65535));
                        1: amt = ref_size;
                        2: amt = ref_size + 16'd1;
                        default: amt = 16'($urandom_range(255));
                    endcase
                end else if (sel < 88) begin
                    op = OP_LOAD;
                    case ($urandom_range(3))
                        0: amt = 16'($urandom_range(65535));
                        1: amt = 16'($urandom_range(1, 4) * 1000);
                        2: amt = $urandom_range(1) ? 16'hFFFF : 16'h0000;
                        default: amt = 16'($urandom_range(4095));
                    endcase
                end else if (sel < 94) begin
                    op = OP_CLEAR;
                    amt = 16'($urandom_range(65535));
                end else begin
                    op = OP_RESERVED;
                    amt = 16'($urandom_range(65535));
                end
                queue_item(op, idx, amt, 8'($urandom_range(255)));
                if (op != OP_RESERVED) taken++;
            end
            wait_until_quiet();
        end

        if (fail_count == 0 && expected_grants.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire
